[rtl/core/fmbq_pkg.sv]
// Package with the shared types and codes of the front-middle-back queue.
`default_nettype none

package fmbq_pkg;

  // Default sizing of the store.
  localparam int DEPTH_DEFAULT      = 64;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // Fixed widths of the channel fields.
  localparam int KIND_W = 3;
  localparam int DOUT_W = 32;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 7;

  // Operation codes carried in the kind field.
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_MID   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_POP_MID    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_REVERSE    = 3'd6;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_POP_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_PUSH_FULL = 2'd2;

  // Cells per first-level group of the pop read tree.
  localparam int GROUP_SIZE = 8;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a request and compute its position
    logic exec;    // shift the cells and update count and orientation
    logic finish;  // load the result register
  } fmbq_cmd_t;

endpackage

`default_nettype wire

[rtl/core/fmbq_in_if.sv]
// Request channel interface of the front-middle-back queue.
`default_nettype none

interface fmbq_in_if;
  logic                            valid;
  logic                            ready;
  logic [fmbq_pkg::KIND_W-1:0]     kind;
  logic signed [fmbq_pkg::DOUT_W-1:0] data_in;

  modport source (output valid, output kind, output data_in, input ready);
  modport sink   (input valid, input kind, input data_in, output ready);
endinterface

`default_nettype wire

[rtl/core/fmbq_out_if.sv]
// Result channel interface of the front-middle-back queue.
`default_nettype none

interface fmbq_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [fmbq_pkg::DOUT_W-1:0] data_out;
  logic [fmbq_pkg::STAT_W-1:0]        status;
  logic [fmbq_pkg::OCC_W-1:0]         occupancy;

  modport source (output valid, output data_out, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input data_out, input status, input occupancy,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/fmbq_ctrl.sv]
// Controller state machine of the front-middle-back queue.
`default_nettype none

module fmbq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output fmbq_pkg::fmbq_cmd_t      cmd
);

  fmbq_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  // State and result-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fmbq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      fmbq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = fmbq_pkg::ST_EXEC;
        end
      end
      fmbq_pkg::ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = fmbq_pkg::ST_FINISH;
      end
      fmbq_pkg::ST_FINISH: begin
        // The result register must be empty or emptying this cycle.
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = fmbq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fmbq_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[rtl/core/fmbq_dpath.sv]
// Datapath of the front-middle-back queue: shifting cell row, count and result.
`default_nettype none

module fmbq_dpath #(
  parameter int DEPTH      = fmbq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = fmbq_pkg::DATA_WIDTH_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire fmbq_pkg::fmbq_cmd_t                 cmd,
  input  wire logic [fmbq_pkg::KIND_W-1:0]         in_kind,
  input  wire logic signed [fmbq_pkg::DOUT_W-1:0]  in_data_in,
  output logic signed [fmbq_pkg::DOUT_W-1:0]       out_data_out,
  output logic [fmbq_pkg::STAT_W-1:0]              out_status,
  output logic [fmbq_pkg::OCC_W-1:0]               out_occupancy
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int GS   = fmbq_pkg::GROUP_SIZE;
  localparam int NG   = (DEPTH + GS - 1) / GS;
  localparam int MINW = (DATA_WIDTH < fmbq_pkg::DOUT_W) ? DATA_WIDTH : fmbq_pkg::DOUT_W;

  // Captured request.
  logic [fmbq_pkg::KIND_W-1:0] kind_r;
  logic [DATA_WIDTH-1:0]       word_r;
  logic [CW-1:0]               pos_r;
  logic                        empty_r;
  logic                        full_r;

  // Architectural state.
  logic [CW-1:0]         count_r, count_nxt;
  logic                  rev_r, rev_nxt;
  logic [DATA_WIDTH-1:0] cells_r   [DEPTH];
  logic [DATA_WIDTH-1:0] cells_nxt [DEPTH];
  logic [DATA_WIDTH-1:0] grp_r     [NG];
  logic [DATA_WIDTH-1:0] grp_nxt   [NG];

  // Result register.
  logic signed [fmbq_pkg::DOUT_W-1:0] data_out_r;
  logic [fmbq_pkg::STAT_W-1:0]        status_r;
  logic [fmbq_pkg::OCC_W-1:0]         occ_r;

  // Decoded kind of the captured request.
  logic is_push, is_pop, do_push, do_pop;
  assign is_push = (kind_r == fmbq_pkg::KIND_PUSH_FRONT) ||
                   (kind_r == fmbq_pkg::KIND_PUSH_MID) ||
                   (kind_r == fmbq_pkg::KIND_PUSH_BACK);
  assign is_pop  = (kind_r == fmbq_pkg::KIND_POP_FRONT) ||
                   (kind_r == fmbq_pkg::KIND_POP_MID) ||
                   (kind_r == fmbq_pkg::KIND_POP_BACK);
  assign do_push = is_push && !full_r;
  assign do_pop  = is_pop && !empty_r;

  // Physical position of the incoming request, mirrored when reversed.
  logic [CW-1:0]         cnt_m1, lpos, pos_calc;
  logic [DATA_WIDTH-1:0] word_calc;
  always_comb begin
    cnt_m1 = count_r - CW'(1);
    lpos   = '0;
    unique case (in_kind)
      fmbq_pkg::KIND_PUSH_MID: lpos = count_r >> 1;
      fmbq_pkg::KIND_PUSH_BACK: lpos = count_r;
      fmbq_pkg::KIND_POP_MID: lpos = cnt_m1 >> 1;
      fmbq_pkg::KIND_POP_BACK: lpos = cnt_m1;
      default: lpos = '0;
    endcase
    if (!rev_r) begin
      pos_calc = lpos;
    end else if ((in_kind == fmbq_pkg::KIND_PUSH_FRONT) ||
                 (in_kind == fmbq_pkg::KIND_PUSH_MID) ||
                 (in_kind == fmbq_pkg::KIND_PUSH_BACK)) begin
      pos_calc = count_r - lpos;
    end else begin
      pos_calc = cnt_m1 - lpos;
    end
    word_calc = '0;
    word_calc[MINW-1:0] = in_data_in[MINW-1:0];
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      word_r  <= word_calc;
      pos_r   <= pos_calc;
      empty_r <= (count_r == '0);
      full_r  <= (count_r == CW'(DEPTH));
    end
  end

  // Cell row: each cell holds, takes its lower or upper neighbor, or the new word.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cells_nxt[i] = cells_r[i];
      if (do_push) begin
        if (CW'(i) == pos_r) begin
          cells_nxt[i] = word_r;
        end else if ((i > 0) && (CW'(i) > pos_r)) begin
          cells_nxt[i] = cells_r[(i > 0) ? i - 1 : 0];
        end
      end else if (do_pop) begin
        if ((i < DEPTH - 1) && (CW'(i) >= pos_r)) begin
          cells_nxt[i] = cells_r[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        cells_r[i] <= cells_nxt[i];
      end
    end
  end

  // First level of the pop read: one-hot select ORed within each group.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GS; k++) begin
        if (g * GS + k < DEPTH) begin
          if (CW'(g * GS + k) == pos_r) begin
            grp_nxt[g] = grp_nxt[g] | cells_r[(g * GS + k < DEPTH) ? g * GS + k : 0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int g = 0; g < NG; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  // Count and orientation updates.
  always_comb begin
    count_nxt = count_r;
    rev_nxt   = rev_r;
    if (cmd.exec) begin
      if (do_push) begin
        count_nxt = count_r + CW'(1);
      end else if (do_pop) begin
        count_nxt = count_r - CW'(1);
      end
      if (kind_r == fmbq_pkg::KIND_REVERSE) begin
        rev_nxt = !rev_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rev_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
    end
  end

  // Second level of the pop read and result formatting.
  logic [DATA_WIDTH-1:0]              pop_word;
  logic signed [fmbq_pkg::DOUT_W-1:0] dout_calc;
  logic [fmbq_pkg::STAT_W-1:0]        stat_calc;
  always_comb begin
    pop_word = '0;
    for (int g = 0; g < NG; g++) begin
      pop_word = pop_word | grp_r[g];
    end
    dout_calc = '0;
    stat_calc = fmbq_pkg::STAT_DONE;
    if (is_pop) begin
      if (empty_r) begin
        dout_calc = '1;
        stat_calc = fmbq_pkg::STAT_POP_EMPTY;
      end else begin
        dout_calc[MINW-1:0] = pop_word[MINW-1:0];
      end
    end else if (is_push && full_r) begin
      stat_calc = fmbq_pkg::STAT_PUSH_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      data_out_r <= dout_calc;
      status_r   <= stat_calc;
      occ_r      <= fmbq_pkg::OCC_W'(count_r);
    end
  end

  assign out_data_out  = data_out_r;
  assign out_status    = status_r;
  assign out_occupancy = occ_r;

endmodule

`default_nettype wire

[rtl/core/front_middle_back_queue.sv]
// Front-middle-back queue: ordered word store with push, pop and reverse at three places.
// Usage:
//   Requests arrive on in_ch (kind and data_in) with a valid/ready handshake.
//   kind selects push front, middle or back, pop front, middle or back, or
//   reverse. Every request yields exactly one result on out_ch: the popped
//   word (all ones for a pop on an empty store, zero for other kinds), a status
//   code and the occupancy after the operation.
//   A request is captured in the cycle it is accepted, the cell row shifts in
//   the next cycle, and the result register loads as soon as it is empty or
//   emptying. A new request is taken only after the previous one has passed
//   through the three-step controller and the registered two-level read tree
//   that picks the popped cell.
//   in_ch.ready is high while the controller is idle, so the next request is
//   taken while an earlier result still waits in the result register.
//   If out_ch.ready stays low, the controller holds the finished request
//   until the result register frees, and no further request is taken.
//   A synchronous active-low reset empties the store and restores normal
//   order. Word contents are not cleared; only occupied cells are read.
`default_nettype none

module front_middle_back_queue #(
  parameter int DEPTH      = fmbq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = fmbq_pkg::DATA_WIDTH_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fmbq_in_if.sink    in_ch,
  fmbq_out_if.source out_ch
);

  fmbq_pkg::fmbq_cmd_t cmd;

  // Controller.
  fmbq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  // Datapath.
  fmbq_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_kind       (in_ch.kind),
    .in_data_in    (in_ch.data_in),
    .out_data_out  (out_ch.data_out),
    .out_status    (out_ch.status),
    .out_occupancy (out_ch.occupancy)
  );

endmodule

`default_nettype wire

[tb/tb_front_middle_back_queue.sv]
// Testbench for the front-middle-back queue: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module tb_front_middle_back_queue;

  localparam int STORE_DEPTH = fmbq_pkg::DEPTH_DEFAULT;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_TARGET = 750;
  localparam int BURST_ITEMS = 100;

  // Kind code that the block treats as no operation.
  localparam logic [fmbq_pkg::KIND_W-1:0] KIND_UNUSED = 3'd7;

  // Fields of one expected result.
  typedef struct packed {
    logic signed [fmbq_pkg::DOUT_W-1:0] data_out;
    logic [fmbq_pkg::STAT_W-1:0]        status;
    logic [fmbq_pkg::OCC_W-1:0]         occupancy;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst_n;

  fmbq_in_if  req_if ();
  fmbq_out_if res_if ();

  front_middle_back_queue dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (req_if),
    .out_ch(res_if)
  );

  always #5 clk = ~clk;

  // Predicted contents of the store, in physical order.
  logic [fmbq_pkg::DOUT_W-1:0] model_words [0:STORE_DEPTH-1];
  int                          model_count;
  bit                          model_flipped;

  queue_result_t expected_results[$];
  int            errors;
  int            items_sent;
  bit            idling_on;
  int            quiet_cycles;

  // Applies one operation to the predicted store and returns its result.
  function automatic queue_result_t apply_queue_op(logic [fmbq_pkg::KIND_W-1:0] kind,
                                                   logic [fmbq_pkg::DOUT_W-1:0] word);
    queue_result_t res;
    int            lpos;
    int            pos;
    int            i;
    res = '0;
    res.status = fmbq_pkg::STAT_DONE;
    case (kind)
      fmbq_pkg::KIND_PUSH_FRONT, fmbq_pkg::KIND_PUSH_MID, fmbq_pkg::KIND_PUSH_BACK: begin
        if (model_count >= STORE_DEPTH) begin
          res.status = fmbq_pkg::STAT_PUSH_FULL;
        end else begin
          if (kind == fmbq_pkg::KIND_PUSH_FRONT) lpos = 0;
          else if (kind == fmbq_pkg::KIND_PUSH_MID) lpos = model_count / 2;
          else lpos = model_count;
          pos = model_flipped ? model_count - lpos : lpos;
          for (i = model_count; i > pos; i--) model_words[i] = model_words[i-1];
          model_words[pos] = word;
          model_count++;
        end
      end
      fmbq_pkg::KIND_POP_FRONT, fmbq_pkg::KIND_POP_MID, fmbq_pkg::KIND_POP_BACK: begin
        if (model_count == 0) begin
          res.data_out = -1;
          res.status   = fmbq_pkg::STAT_POP_EMPTY;
        end else begin
          if (kind == fmbq_pkg::KIND_POP_FRONT) lpos = 0;
          else if (kind == fmbq_pkg::KIND_POP_MID) lpos = (model_count - 1) / 2;
          else lpos = model_count - 1;
          pos = model_flipped ? model_count - 1 - lpos : lpos;
          res.data_out = model_words[pos];
          for (i = pos; i + 1 < model_count; i++) model_words[i] = model_words[i+1];
          model_count--;
        end
      end
      fmbq_pkg::KIND_REVERSE: model_flipped = !model_flipped;
      default: ;
    endcase
    res.occupancy = fmbq_pkg::OCC_W'(model_count);
    return res;
  endfunction

  // Words biased toward the extremes of the signed range, minus one, zero and small values.
  function automatic logic [fmbq_pkg::DOUT_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0;
      4: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [fmbq_pkg::KIND_W-1:0] pick_push();
    case ($urandom_range(0, 2))
      0: return fmbq_pkg::KIND_PUSH_FRONT;
      1: return fmbq_pkg::KIND_PUSH_MID;
      default: return fmbq_pkg::KIND_PUSH_BACK;
    endcase
  endfunction

  function automatic logic [fmbq_pkg::KIND_W-1:0] pick_pop();
    case ($urandom_range(0, 2))
      0: return fmbq_pkg::KIND_POP_FRONT;
      1: return fmbq_pkg::KIND_POP_MID;
      default: return fmbq_pkg::KIND_POP_BACK;
    endcase
  endfunction

  // Mixed operation; push_pct sets the share of pushes among the requests.
  function automatic logic [fmbq_pkg::KIND_W-1:0] pick_kind(int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return KIND_UNUSED;
    if (r < 10) return fmbq_pkg::KIND_REVERSE;
    if (r < 10 + push_pct) return pick_push();
    return pick_pop();
  endfunction

  // Sends one request; entered and left at a falling edge, valid high on return unless idling.
  task automatic issue_request(logic [fmbq_pkg::KIND_W-1:0] kind,
                               logic [fmbq_pkg::DOUT_W-1:0] word);
    req_if.valid   <= 1'b1;
    req_if.kind    <= kind;
    req_if.data_in <= word;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    expected_results.push_back(apply_queue_op(kind, word));
    items_sent++;
    @(negedge clk);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // Lowers valid, waits until no result is outstanding, then returns at the next falling edge.
  task automatic wait_until_idle();
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Empty-store pops, small middle operations, reverse on tiny stores, unused kind.
  task automatic test_empty_and_small();
    issue_request(fmbq_pkg::KIND_POP_FRONT, 32'h1234_5678);
    issue_request(fmbq_pkg::KIND_POP_MID, 32'h0);
    issue_request(fmbq_pkg::KIND_POP_BACK, 32'hFFFF_FFFF);
    issue_request(fmbq_pkg::KIND_REVERSE, 32'h0);
    issue_request(KIND_UNUSED, 32'hFFFF_FFFF);
    issue_request(fmbq_pkg::KIND_PUSH_MID, 32'h7FFF_FFFF);
    issue_request(fmbq_pkg::KIND_REVERSE, 32'h0);
    issue_request(fmbq_pkg::KIND_POP_MID, 32'h0);
    issue_request(fmbq_pkg::KIND_PUSH_MID, 32'h8000_0000);
    issue_request(fmbq_pkg::KIND_PUSH_MID, 32'h0);
    issue_request(fmbq_pkg::KIND_PUSH_FRONT, 32'hFFFF_FFFF);
    issue_request(fmbq_pkg::KIND_PUSH_BACK, 32'h0000_0001);
    issue_request(fmbq_pkg::KIND_PUSH_MID, 32'hA5A5_5A5A);
    issue_request(fmbq_pkg::KIND_REVERSE, 32'h0);
    issue_request(fmbq_pkg::KIND_POP_MID, 32'h0);
    issue_request(fmbq_pkg::KIND_POP_FRONT, 32'h0);
    issue_request(fmbq_pkg::KIND_POP_BACK, 32'h0);
    issue_request(fmbq_pkg::KIND_PUSH_FRONT, 32'h5A5A_A5A5);
    issue_request(fmbq_pkg::KIND_PUSH_BACK, 32'h8000_0001);
    issue_request(KIND_UNUSED, 32'h0);
    issue_request(fmbq_pkg::KIND_REVERSE, 32'h0);
    issue_request(fmbq_pkg::KIND_POP_MID, 32'h0);
    issue_request(fmbq_pkg::KIND_POP_MID, 32'h0);
    issue_request(fmbq_pkg::KIND_POP_BACK, 32'h0);
    issue_request(fmbq_pkg::KIND_POP_BACK, 32'h0);
  endtask

  // Pushes until the store is full, then pushes that must be dropped, a pop and pushes after it.
  task automatic test_fill_to_full();
    while (model_count < STORE_DEPTH) begin
      if ($urandom_range(0, 7) == 0) issue_request(fmbq_pkg::KIND_REVERSE, $urandom);
      else issue_request(pick_push(), pick_word());
    end
    issue_request(fmbq_pkg::KIND_PUSH_FRONT, $urandom);
    issue_request(fmbq_pkg::KIND_PUSH_MID, $urandom);
    issue_request(fmbq_pkg::KIND_PUSH_BACK, $urandom);
    issue_request(fmbq_pkg::KIND_REVERSE, 32'h0);
    issue_request(fmbq_pkg::KIND_POP_MID, 32'h0);
    issue_request(fmbq_pkg::KIND_PUSH_MID, pick_word());
    issue_request(fmbq_pkg::KIND_PUSH_BACK, pick_word());
  endtask

  // Pops until the store is empty, then pops that find it empty.
  task automatic test_drain_to_empty();
    while (model_count > 0) begin
      if ($urandom_range(0, 7) == 0) issue_request(fmbq_pkg::KIND_REVERSE, $urandom);
      else issue_request(pick_pop(), $urandom);
    end
    issue_request(fmbq_pkg::KIND_POP_BACK, $urandom);
    issue_request(fmbq_pkg::KIND_POP_MID, $urandom);
    issue_request(fmbq_pkg::KIND_POP_FRONT, $urandom);
  endtask

  // Sender holds off until every outstanding result has come back.
  task automatic test_pause_until_idle();
    repeat (12) issue_request(pick_kind(60), pick_word());
    wait_until_idle();
    repeat (12) issue_request(pick_kind(40), pick_word());
  endtask

  // Phases that lean toward filling, draining or neither.
  task automatic test_random_mix();
    int push_pct;
    while (items_sent < RANDOM_TARGET) begin
      case ($urandom_range(0, 2))
        0: push_pct = 70;
        1: push_pct = 20;
        default: push_pct = 45;
      endcase
      repeat ($urandom_range(20, 80)) issue_request(pick_kind(push_pct), pick_word());
    end
  endtask

  // Last stretch with no idling on either side.
  task automatic test_back_to_back();
    idling_on = 1'b0;
    repeat (BURST_ITEMS / 2) issue_request(pick_kind(60), pick_word());
    repeat (BURST_ITEMS / 2) issue_request(pick_kind(30), pick_word());
  endtask

  // Result sink with random stall bursts.
  initial begin
    int stall_left;
    stall_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 12) - 1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    queue_result_t exp_res;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got data_out %0d status %0d occ %0d",
                 $time, res_if.data_out, res_if.status, res_if.occupancy);
      end else begin
        exp_res = expected_results.pop_front();
        if (res_if.data_out !== exp_res.data_out) begin
          errors++;
          $display("%0t: data_out expected %0d got %0d", $time, exp_res.data_out,
                   res_if.data_out);
        end
        if (res_if.status !== exp_res.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, exp_res.status,
                   res_if.status);
        end
        if (res_if.occupancy !== exp_res.occupancy) begin
          errors++;
          $display("%0t: occupancy expected %0d got %0d", $time, exp_res.occupancy,
                   res_if.occupancy);
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a request or result.
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("front_middle_back_queue: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    req_if.valid   = 1'b0;
    req_if.kind    = fmbq_pkg::KIND_PUSH_FRONT;
    req_if.data_in = '0;
    quiet_cycles   = 0;
    errors         = 0;
    items_sent     = 0;
    idling_on      = 1'b1;
    model_count    = 0;
    model_flipped  = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_and_small();
    test_fill_to_full();
    test_drain_to_empty();
    test_pause_until_idle();
    test_random_mix();
    test_back_to_back();

    // Let the last results arrive, then allow for any late extra result.
    wait_until_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      errors++;
      $display("%0t: results outstanding expected 0 got %0d", $time,
               expected_results.size());
    end
    if (errors == 0) begin
      $display("front_middle_back_queue: match");
    end else begin
      $display("front_middle_back_queue: mismatch");
    end
    $finish;
  end

endmodule

[front_middle_back_queue.f]
rtl/core/fmbq_pkg.sv
rtl/core/fmbq_in_if.sv
rtl/core/fmbq_out_if.sv
rtl/core/fmbq_ctrl.sv
rtl/core/fmbq_dpath.sv
rtl/core/front_middle_back_queue.sv
tb/tb_front_middle_back_queue.sv
